// File: rtl/core/pressure_sensor_read_sequencer_defines.svh
// assertion macros shared by the sequencer rtl
// used by files that carry concurrent checks; no other dependencies
`ifndef PRESSURE_SENSOR_READ_SEQUENCER_DEFINES_SVH
`define PRESSURE_SENSOR_READ_SEQUENCER_DEFINES_SVH

// same-cycle implication, checks off while in reset
`define PSRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// next-cycle implication, checks off while in reset
`define PSRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// File: rtl/core/psrs_pkg.sv
// shared types, codes and constants of the pressure sensor read sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psrs_pkg;

    // default sizes
    localparam int STORE_BYTES_DEF = 22;
    localparam int TICK_WIDTH_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_WIDTH       = 32;

    // input operation codes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_COMMAND   = 2'd1;
    localparam logic [1:0] OP_HOST_READ = 2'd2;
    localparam logic [1:0] OP_RX_BYTE   = 2'd3;

    // host command code that selects the calibration sequence
    localparam logic [7:0] CMD_CALIBRATE = 8'd1;

    // host read selects
    localparam logic [1:0] SEL_NONE     = 2'd0;
    localparam logic [1:0] SEL_READINGS = 2'd1;
    localparam logic [1:0] SEL_TABLE_LO = 2'd2;
    localparam logic [1:0] SEL_TABLE_HI = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_DEADLINE   = 2'd0;
    localparam logic [1:0] REG_TEMP_WAIT  = 2'd1;
    localparam logic [1:0] REG_PRESS_WAIT = 2'd2;

    // configuration reset values
    localparam logic [CFG_WIDTH-1:0] DEADLINE_RST   = 32'd1000;
    localparam logic [CFG_WIDTH-1:0] TEMP_WAIT_RST  = 32'd5;
    localparam logic [CFG_WIDTH-1:0] PRESS_WAIT_RST = 32'd30;

    // result kinds
    localparam logic [1:0] RES_COMMAND = 2'd0;
    localparam logic [1:0] RES_DATA    = 2'd1;
    localparam logic [1:0] RES_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_BUSY     = 2'd0;
    localparam logic [1:0] ERR_DEADLINE = 2'd1;
    localparam logic [1:0] ERR_BAD_ID   = 2'd2;

    // bus constants
    localparam logic [7:0] ADDR_RD      = 8'hef;
    localparam logic [7:0] ADDR_WR      = 8'hee;
    localparam logic [7:0] REG_ID       = 8'hd0;
    localparam logic [7:0] REG_TABLE    = 8'haa;
    localparam logic [7:0] REG_CTRL     = 8'hf4;
    localparam logic [7:0] REG_RESULT   = 8'hf6;
    localparam logic [7:0] CTRL_TEMP    = 8'h2e;
    localparam logic [7:0] CTRL_PRESS   = 8'hf4;
    localparam logic [7:0] DEVICE_ID    = 8'h55;
    localparam logic [4:0] LEN_TABLE    = 5'd22;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ASK_ID,
        PH_RCV_ID,
        PH_ASK_TABLE,
        PH_ASK_TEMP,
        PH_ASK_TEMP2,
        PH_WAIT_TEMP,
        PH_ASK_PRESS,
        PH_ASK_PRESS2,
        PH_WAIT_DATA
    } phase_t;

    // classified item kinds
    typedef enum logic [1:0] {
        JOB_TICK,
        JOB_COMMAND,
        JOB_HOST_READ,
        JOB_RX_BYTE
    } job_kind_t;

    // classified item as queued between front and back
    typedef struct packed {
        job_kind_t  kind;
        logic       master_busy;
        logic       calibrate;
        logic [1:0] sel;
        logic [7:0] rx_byte;
    } job_t;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] bus_address;
        logic [4:0] transfer_length;
        logic [7:0] send_first;
        logic [7:0] send_second;
        logic [7:0] read_data;
        logic       last_of_run;
        logic [1:0] error_code;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/pressure_sensor_read_sequencer.sv
// top level of the pressure sensor read sequencer
// instantiates psrs_front, psrs_queue and psrs_back; uses psrs_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Items enter on start while busy is low: a tick (with the I2C master's busy
//   flag), a host command, a host register read or a byte received from the bus.
//   Results leave on result_strobe, one per cycle, each valid for that cycle
//   only; the receiver cannot stall, so nothing is held back for it.
//   Configuration registers are written on cfg_valid (cfg_ready is always high);
//   write only while the block is idle; the block itself does not enforce this.
// Queueing and flow
//   An item is classified on entry and queued in a short job queue; the back end
//   takes one job per cycle while no host read run is active, and its result is
//   registered. A host register read emits its run of 5, 16 or 6 bytes on
//   consecutive cycles; the back end takes no job during the run, so the queue
//   can fill and busy rise. Otherwise one item per cycle is taken.
// Reset
//   rst_n clears the phase to idle, the counters, the id byte and the queue,
//   and loads the registers with their defaults; the sample store is not
//   cleared and is read only after a sequence has filled it.
module pressure_sensor_read_sequencer
#(
    parameter int STORE_BYTES = psrs_pkg::STORE_BYTES_DEF,
    parameter int TICK_WIDTH  = psrs_pkg::TICK_WIDTH_DEF,
    parameter int QUEUE_DEPTH = psrs_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     operation,
    input  wire logic                           master_busy,
    input  wire logic [7:0]                     command_code,
    input  wire logic [1:0]                     register_select,
    input  wire logic [7:0]                     received_byte,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [psrs_pkg::CFG_WIDTH-1:0] cfg_data,
    output logic                                result_strobe,
    output logic [1:0]                          result_kind,
    output logic [7:0]                          bus_address,
    output logic [4:0]                          transfer_length,
    output logic [7:0]                          send_first,
    output logic [7:0]                          send_second,
    output logic [7:0]                          read_data,
    output logic                                last_of_run,
    output logic [1:0]                          error_code
);

    logic              queue_full;
    logic              queue_empty;
    logic              push;
    logic              pop;
    psrs_pkg::job_t    in_job;
    psrs_pkg::job_t    head_job;
    psrs_pkg::result_t res;

    assign cfg_ready = 1'b1;

    // classify incoming items
    psrs_front u_front
    (
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .master_busy     (master_busy),
        .command_code    (command_code),
        .register_select (register_select),
        .received_byte   (received_byte),
        .queue_full      (queue_full),
        .push            (push),
        .job             (in_job)
    );

    // job queue
    psrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (in_job),
        .full     (queue_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    // sequencer and result stage
    psrs_back #(
        .STORE_BYTES (STORE_BYTES),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_empty (queue_empty),
        .job         (head_job),
        .pop         (pop),
        .res_strobe  (result_strobe),
        .res         (res)
    );

    // result fields
    assign result_kind     = res.kind;
    assign bus_address     = res.bus_address;
    assign transfer_length = res.transfer_length;
    assign send_first      = res.send_first;
    assign send_second     = res.send_second;
    assign read_data       = res.read_data;
    assign last_of_run     = res.last_of_run;
    assign error_code      = res.error_code;

endmodule

`default_nettype wire

// File: rtl/core/psrs_front.sv
// front end: takes items from the host side and classifies them into jobs
// depends on psrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module psrs_front
(
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       operation,
    input  wire logic             master_busy,
    input  wire logic [7:0]       command_code,
    input  wire logic [1:0]       register_select,
    input  wire logic [7:0]       received_byte,
    input  wire logic             queue_full,
    output logic                  push,
    output psrs_pkg::job_t        job
);

    // accept whenever the queue has room
    assign busy = queue_full;
    assign push = start && !queue_full;

    // classify the item
    always_comb
    begin
        job.master_busy = master_busy;
        job.calibrate   = (command_code == psrs_pkg::CMD_CALIBRATE);
        job.sel         = register_select;
        job.rx_byte     = received_byte;
        unique case (operation)
            psrs_pkg::OP_TICK:      job.kind = psrs_pkg::JOB_TICK;
            psrs_pkg::OP_COMMAND:   job.kind = psrs_pkg::JOB_COMMAND;
            psrs_pkg::OP_HOST_READ: job.kind = psrs_pkg::JOB_HOST_READ;
            default:                job.kind = psrs_pkg::JOB_RX_BYTE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/psrs_queue.sv
// short job queue between front and back
// depends on psrs_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "pressure_sensor_read_sequencer_defines.svh"

module psrs_queue
#(
    parameter int DEPTH = psrs_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire psrs_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output psrs_pkg::job_t      head_job,
    output logic                empty
);

    localparam int IdxW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    psrs_pkg::job_t slot_reg [DEPTH];
    logic [IdxW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // occupancy stays in range, a push never meets a full queue
    // and a pop never meets an empty one
    `PSRS_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= CntW'(DEPTH))
    `PSRS_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full)
    `PSRS_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty)

endmodule

`default_nettype wire

// File: rtl/core/psrs_back.sv
// back end: sequencer state machine, sample store, config registers, results
// depends on psrs_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "pressure_sensor_read_sequencer_defines.svh"

module psrs_back
#(
    parameter int STORE_BYTES = psrs_pkg::STORE_BYTES_DEF,
    parameter int TICK_WIDTH  = psrs_pkg::TICK_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [psrs_pkg::CFG_WIDTH-1:0] cfg_data,
    input  wire logic                           queue_empty,
    input  wire psrs_pkg::job_t                 job,
    output logic                                pop,
    output logic                                res_strobe,
    output psrs_pkg::result_t                   res
);

    localparam int IdxW = $clog2(STORE_BYTES);
    localparam int PtrW = $clog2(STORE_BYTES + 1);
    localparam int CmpW = (TICK_WIDTH > psrs_pkg::CFG_WIDTH) ? TICK_WIDTH
                                                             : psrs_pkg::CFG_WIDTH;

    // config registers
    logic [psrs_pkg::CFG_WIDTH-1:0] deadline_reg;
    logic [psrs_pkg::CFG_WIDTH-1:0] temp_wait_reg;
    logic [psrs_pkg::CFG_WIDTH-1:0] press_wait_reg;

    // sequencer state
    psrs_pkg::phase_t phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [PtrW-1:0]       ptr_reg, ptr_next;
    logic [7:0]            id_reg, id_next;
    logic [7:0]            store_reg [STORE_BYTES];
    logic                  store_we;

    // host read run
    logic            rd_active_reg, rd_active_next;
    logic [IdxW-1:0] rd_idx_reg, rd_idx_next;
    logic [IdxW-1:0] rd_last_reg, rd_last_next;

    // result stage
    logic              strobe_reg, strobe_next;
    psrs_pkg::result_t res_reg, res_next;

    // shared conditions
    logic [TICK_WIDTH-1:0] elapsed_inc;
    logic [CmpW-1:0]       elapsed_ext;
    logic                  is_idle;
    logic                  missed;
    logic                  temp_done;
    logic                  press_done;
    logic                  run_tick;
    logic                  store_room;

    assign pop        = !queue_empty && !rd_active_reg;
    assign res_strobe = strobe_reg;
    assign res        = res_reg;

    // saturating elapsed count and its compares
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign elapsed_ext = CmpW'(elapsed_inc);
    assign is_idle     = (phase_reg == psrs_pkg::PH_IDLE);
    assign missed      = elapsed_ext > CmpW'(deadline_reg);
    assign temp_done   = elapsed_ext > CmpW'(temp_wait_reg);
    assign press_done  = elapsed_ext > CmpW'(press_wait_reg);
    assign run_tick    = pop && (job.kind == psrs_pkg::JOB_TICK) && !is_idle;
    assign store_room  = ptr_reg < PtrW'(STORE_BYTES);

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        ptr_next       = ptr_reg;
        id_next        = id_reg;
        store_we       = 1'b0;
        rd_active_next = rd_active_reg;
        rd_idx_next    = rd_idx_reg;
        rd_last_next   = rd_last_reg;

        if (rd_active_reg)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
            if (rd_idx_reg == rd_last_reg)
            begin
                rd_active_next = 1'b0;
            end
        end
        else if (pop)
        begin
            unique case (job.kind)
                psrs_pkg::JOB_TICK:
                begin
                    if (!is_idle)
                    begin
                        elapsed_next = elapsed_inc;
                        if (missed)
                        begin
                            phase_next = psrs_pkg::PH_IDLE;
                        end
                        else if (!job.master_busy)
                        begin
                            unique case (phase_reg)
                                psrs_pkg::PH_ASK_ID:
                                    phase_next = psrs_pkg::PH_RCV_ID;
                                psrs_pkg::PH_RCV_ID:
                                    phase_next = (id_reg == psrs_pkg::DEVICE_ID)
                                                 ? psrs_pkg::PH_ASK_TABLE
                                                 : psrs_pkg::PH_IDLE;
                                psrs_pkg::PH_ASK_TABLE:
                                begin
                                    ptr_next   = '0;
                                    phase_next = psrs_pkg::PH_WAIT_DATA;
                                end
                                psrs_pkg::PH_ASK_TEMP:
                                begin
                                    if (temp_done)
                                    begin
                                        phase_next = psrs_pkg::PH_ASK_TEMP2;
                                    end
                                end
                                psrs_pkg::PH_ASK_TEMP2:
                                begin
                                    ptr_next   = '0;
                                    phase_next = psrs_pkg::PH_WAIT_TEMP;
                                end
                                psrs_pkg::PH_WAIT_TEMP:
                                begin
                                    elapsed_next = '0;
                                    phase_next   = psrs_pkg::PH_ASK_PRESS;
                                end
                                psrs_pkg::PH_ASK_PRESS:
                                begin
                                    if (press_done)
                                    begin
                                        phase_next = psrs_pkg::PH_ASK_PRESS2;
                                    end
                                end
                                psrs_pkg::PH_ASK_PRESS2:
                                begin
                                    ptr_next   = PtrW'(2);
                                    phase_next = psrs_pkg::PH_WAIT_DATA;
                                end
                                default:
                                    phase_next = psrs_pkg::PH_IDLE;
                            endcase
                        end
                    end
                end
                psrs_pkg::JOB_COMMAND:
                begin
                    if (is_idle)
                    begin
                        elapsed_next = '0;
                        phase_next   = job.calibrate ? psrs_pkg::PH_ASK_ID
                                                     : psrs_pkg::PH_ASK_TEMP;
                    end
                end
                psrs_pkg::JOB_HOST_READ:
                begin
                    if (is_idle)
                    begin
                        case (job.sel)
                            psrs_pkg::SEL_READINGS:
                            begin
                                rd_active_next = 1'b1;
                                rd_idx_next    = '0;
                                rd_last_next   = IdxW'(4);
                            end
                            psrs_pkg::SEL_TABLE_LO:
                            begin
                                rd_active_next = 1'b1;
                                rd_idx_next    = '0;
                                rd_last_next   = IdxW'(15);
                            end
                            psrs_pkg::SEL_TABLE_HI:
                            begin
                                rd_active_next = 1'b1;
                                rd_idx_next    = IdxW'(16);
                                rd_last_next   = IdxW'(STORE_BYTES - 1);
                            end
                            default:
                                rd_active_next = 1'b0;
                        endcase
                    end
                end
                default:
                begin
                    // received byte
                    if (phase_reg == psrs_pkg::PH_RCV_ID)
                    begin
                        id_next = job.rx_byte;
                    end
                    else if ((phase_reg == psrs_pkg::PH_WAIT_TEMP ||
                              phase_reg == psrs_pkg::PH_WAIT_DATA) && store_room)
                    begin
                        store_we = 1'b1;
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    // result outputs
    always_comb
    begin
        strobe_next = 1'b0;
        res_next    = '0;

        if (rd_active_reg)
        begin
            strobe_next          = 1'b1;
            res_next.kind        = psrs_pkg::RES_DATA;
            res_next.read_data   = store_reg[rd_idx_reg];
            res_next.last_of_run = (rd_idx_reg == rd_last_reg);
        end
        else if (pop)
        begin
            case (job.kind)
                psrs_pkg::JOB_TICK:
                begin
                    if (run_tick && missed)
                    begin
                        strobe_next         = 1'b1;
                        res_next.kind       = psrs_pkg::RES_ERROR;
                        res_next.error_code = psrs_pkg::ERR_DEADLINE;
                    end
                    else if (run_tick && !job.master_busy)
                    begin
                        unique case (phase_reg)
                            psrs_pkg::PH_ASK_ID:
                            begin
                                strobe_next              = 1'b1;
                                res_next.bus_address     = psrs_pkg::ADDR_RD;
                                res_next.transfer_length = 5'd1;
                            end
                            psrs_pkg::PH_RCV_ID:
                            begin
                                strobe_next = 1'b1;
                                if (id_reg != psrs_pkg::DEVICE_ID)
                                begin
                                    res_next.kind       = psrs_pkg::RES_ERROR;
                                    res_next.error_code = psrs_pkg::ERR_BAD_ID;
                                end
                                else
                                begin
                                    res_next.bus_address     = psrs_pkg::ADDR_WR;
                                    res_next.transfer_length = 5'd1;
                                    res_next.send_first      = psrs_pkg::REG_TABLE;
                                end
                            end
                            psrs_pkg::PH_ASK_TABLE:
                            begin
                                strobe_next              = 1'b1;
                                res_next.bus_address     = psrs_pkg::ADDR_RD;
                                res_next.transfer_length = psrs_pkg::LEN_TABLE;
                            end
                            psrs_pkg::PH_ASK_TEMP:
                            begin
                                strobe_next              = temp_done;
                                res_next.bus_address     = psrs_pkg::ADDR_WR;
                                res_next.transfer_length = 5'd1;
                                res_next.send_first      = psrs_pkg::REG_RESULT;
                            end
                            psrs_pkg::PH_ASK_TEMP2:
                            begin
                                strobe_next              = 1'b1;
                                res_next.bus_address     = psrs_pkg::ADDR_RD;
                                res_next.transfer_length = 5'd2;
                            end
                            psrs_pkg::PH_WAIT_TEMP:
                            begin
                                strobe_next              = 1'b1;
                                res_next.bus_address     = psrs_pkg::ADDR_WR;
                                res_next.transfer_length = 5'd2;
                                res_next.send_first      = psrs_pkg::REG_CTRL;
                                res_next.send_second     = psrs_pkg::CTRL_PRESS;
                            end
                            psrs_pkg::PH_ASK_PRESS:
                            begin
                                strobe_next              = press_done;
                                res_next.bus_address     = psrs_pkg::ADDR_WR;
                                res_next.transfer_length = 5'd1;
                                res_next.send_first      = psrs_pkg::REG_RESULT;
                            end
                            psrs_pkg::PH_ASK_PRESS2:
                            begin
                                strobe_next              = 1'b1;
                                res_next.bus_address     = psrs_pkg::ADDR_RD;
                                res_next.transfer_length = 5'd3;
                            end
                            default:
                                strobe_next = 1'b0;
                        endcase
                    end
                end
                psrs_pkg::JOB_COMMAND:
                begin
                    strobe_next = 1'b1;
                    if (!is_idle)
                    begin
                        res_next.kind       = psrs_pkg::RES_ERROR;
                        res_next.error_code = psrs_pkg::ERR_BUSY;
                    end
                    else if (job.calibrate)
                    begin
                        res_next.bus_address     = psrs_pkg::ADDR_WR;
                        res_next.transfer_length = 5'd1;
                        res_next.send_first      = psrs_pkg::REG_ID;
                    end
                    else
                    begin
                        res_next.bus_address     = psrs_pkg::ADDR_WR;
                        res_next.transfer_length = 5'd2;
                        res_next.send_first      = psrs_pkg::REG_CTRL;
                        res_next.send_second     = psrs_pkg::CTRL_TEMP;
                    end
                end
                psrs_pkg::JOB_HOST_READ:
                begin
                    if (!is_idle)
                    begin
                        strobe_next         = 1'b1;
                        res_next.kind       = psrs_pkg::RES_ERROR;
                        res_next.error_code = psrs_pkg::ERR_BUSY;
                    end
                end
                default:
                    strobe_next = 1'b0;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg   <= psrs_pkg::DEADLINE_RST;
            temp_wait_reg  <= psrs_pkg::TEMP_WAIT_RST;
            press_wait_reg <= psrs_pkg::PRESS_WAIT_RST;
            phase_reg      <= psrs_pkg::PH_IDLE;
            elapsed_reg    <= '0;
            ptr_reg        <= '0;
            id_reg         <= '0;
            rd_active_reg  <= 1'b0;
            rd_idx_reg     <= '0;
            rd_last_reg    <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    psrs_pkg::REG_DEADLINE:   deadline_reg   <= cfg_data;
                    psrs_pkg::REG_TEMP_WAIT:  temp_wait_reg  <= cfg_data;
                    psrs_pkg::REG_PRESS_WAIT: press_wait_reg <= cfg_data;
                    default:                  deadline_reg   <= deadline_reg;
                endcase
            end
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            ptr_reg       <= ptr_next;
            id_reg        <= id_next;
            rd_active_reg <= rd_active_next;
            rd_idx_reg    <= rd_idx_next;
            rd_last_reg   <= rd_last_next;
            strobe_reg    <= strobe_next;
        end
    end

    // sample store and result payload
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[ptr_reg[IdxW-1:0]] <= job.rx_byte;
        end
        res_reg <= res_next;
    end

    // a host read run only happens while idle and gives one data item per cycle
    `PSRS_ASSERT_NOW(a_run_while_idle, clk, rst_n, rd_active_reg,
                     phase_reg == psrs_pkg::PH_IDLE)
    `PSRS_ASSERT_NEXT(a_run_emits, clk, rst_n, rd_active_reg,
                      strobe_reg && res_reg.kind == psrs_pkg::RES_DATA)
    `PSRS_ASSERT_NOW(a_ptr_range, clk, rst_n, 1'b1, ptr_reg <= PtrW'(STORE_BYTES))

endmodule

`default_nettype wire

// File: dv/pressure_sensor_read_sequencer_test.sv
// self-checking testbench for the pressure sensor read sequencer
// drives directed and random sequences, predicts every result in place
// depends on psrs_pkg and pressure_sensor_read_sequencer
`timescale 1ns / 1ps

module pressure_sensor_read_sequencer_test;

    import psrs_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SEQ_STEP_CAP = 500;

    // one input item as driven on the ports
    typedef struct {
        logic [1:0] op;
        logic       mbusy;
        logic [7:0] code;
        logic [1:0] sel;
        logic [7:0] rxb;
    } sensor_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           operation;
    logic                 master_busy;
    logic [7:0]           command_code;
    logic [1:0]           register_select;
    logic [7:0]           received_byte;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;
    logic                 result_strobe;
    logic [1:0]           result_kind;
    logic [7:0]           bus_address;
    logic [4:0]           transfer_length;
    logic [7:0]           send_first;
    logic [7:0]           send_second;
    logic [7:0]           read_data;
    logic                 last_of_run;
    logic [1:0]           error_code;

    pressure_sensor_read_sequencer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .master_busy     (master_busy),
        .command_code    (command_code),
        .register_select (register_select),
        .received_byte   (received_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_strobe   (result_strobe),
        .result_kind     (result_kind),
        .bus_address     (bus_address),
        .transfer_length (transfer_length),
        .send_first      (send_first),
        .send_second     (send_second),
        .read_data       (read_data),
        .last_of_run     (last_of_run),
        .error_code      (error_code)
    );

    // sequencer state as the testbench sees it
    phase_t                    ph;
    logic [TICK_WIDTH_DEF-1:0] elapsed;
    logic [7:0]                store [STORE_BYTES_DEF];
    bit                        written [STORE_BYTES_DEF];
    logic [4:0]                ptr;
    logic [7:0]                id_seen;
    logic [CFG_WIDTH-1:0]      deadline_cfg;
    logic [CFG_WIDTH-1:0]      temp_wait_cfg;
    logic [CFG_WIDTH-1:0]      press_wait_cfg;

    result_t results_due [$];
    result_t checked;
    int      mismatches;
    int      items_sent;
    int      burst_left;
    bit      steady;
    int      quiet;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t make_result(logic [1:0] kind, logic [7:0] addr, logic [4:0] len,
                                            logic [7:0] b0, logic [7:0] b1, logic [7:0] data,
                                            logic last, logic [1:0] err);
        result_t r;
        r.kind            = kind;
        r.bus_address     = addr;
        r.transfer_length = len;
        r.send_first      = b0;
        r.send_second     = b1;
        r.read_data       = data;
        r.last_of_run     = last;
        r.error_code      = err;
        return r;
    endfunction

    function automatic void due_command(logic [7:0] addr, logic [4:0] len, logic [7:0] b0,
                                        logic [7:0] b1);
        results_due.push_back(make_result(RES_COMMAND, addr, len, b0, b1, 8'h00, 1'b0, ERR_BUSY));
    endfunction

    function automatic void due_error(logic [1:0] code);
        results_due.push_back(make_result(RES_ERROR, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00, 1'b0, code));
    endfunction

    function automatic bit bytes_written(int first, int count);
        for (int i = first; i < first + count; i++)
        begin
            if (!written[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // tick handling: deadline first, then the master busy test, then the phase step
    function automatic void sequencer_tick(logic mbusy);
        if (ph == PH_IDLE)
            return;
        if (elapsed != '1)
            elapsed = elapsed + 1'b1;
        if (elapsed > deadline_cfg)
        begin
            ph = PH_IDLE;
            due_error(ERR_DEADLINE);
            return;
        end
        if (mbusy)
            return;
        case (ph)
            PH_ASK_ID:
            begin
                ph = PH_RCV_ID;
                due_command(ADDR_RD, 5'd1, 8'h00, 8'h00);
            end
            PH_RCV_ID:
            begin
                if (id_seen != DEVICE_ID)
                begin
                    ph = PH_IDLE;
                    due_error(ERR_BAD_ID);
                end
                else
                begin
                    ph = PH_ASK_TABLE;
                    due_command(ADDR_WR, 5'd1, REG_TABLE, 8'h00);
                end
            end
            PH_ASK_TABLE:
            begin
                ptr = 5'd0;
                ph  = PH_WAIT_DATA;
                due_command(ADDR_RD, LEN_TABLE, 8'h00, 8'h00);
            end
            PH_ASK_TEMP:
            begin
                if (elapsed > temp_wait_cfg)
                begin
                    ph = PH_ASK_TEMP2;
                    due_command(ADDR_WR, 5'd1, REG_RESULT, 8'h00);
                end
            end
            PH_ASK_TEMP2:
            begin
                ptr = 5'd0;
                ph  = PH_WAIT_TEMP;
                due_command(ADDR_RD, 5'd2, 8'h00, 8'h00);
            end
            PH_WAIT_TEMP:
            begin
                elapsed = '0;
                ph      = PH_ASK_PRESS;
                due_command(ADDR_WR, 5'd2, REG_CTRL, CTRL_PRESS);
            end
            PH_ASK_PRESS:
            begin
                if (elapsed > press_wait_cfg)
                begin
                    ph = PH_ASK_PRESS2;
                    due_command(ADDR_WR, 5'd1, REG_RESULT, 8'h00);
                end
            end
            PH_ASK_PRESS2:
            begin
                ptr = 5'd2;
                ph  = PH_WAIT_DATA;
                due_command(ADDR_RD, 5'd3, 8'h00, 8'h00);
            end
            default:
                ph = PH_IDLE;
        endcase
    endfunction

    // advance the sequencer state by one accepted item and queue its results
    function automatic void sequence_step(sensor_item_t it);
        int first;
        int count;
        first = 0;
        count = 0;
        case (it.op)
            OP_TICK:
                sequencer_tick(it.mbusy);
            OP_COMMAND:
            begin
                if (ph != PH_IDLE)
                    due_error(ERR_BUSY);
                else
                begin
                    elapsed = '0;
                    if (it.code == CMD_CALIBRATE)
                    begin
                        ph = PH_ASK_ID;
                        due_command(ADDR_WR, 5'd1, REG_ID, 8'h00);
                    end
                    else
                    begin
                        ph = PH_ASK_TEMP;
                        due_command(ADDR_WR, 5'd2, REG_CTRL, CTRL_TEMP);
                    end
                end
            end
            OP_HOST_READ:
            begin
                if (ph != PH_IDLE)
                    due_error(ERR_BUSY);
                else
                begin
                    case (it.sel)
                        SEL_READINGS: begin first = 0;  count = 5;                    end
                        SEL_TABLE_LO: begin first = 0;  count = 16;                   end
                        SEL_TABLE_HI: begin first = 16; count = STORE_BYTES_DEF - 16; end
                        default:      count = 0;
                    endcase
                    for (int i = 0; i < count; i++)
                        results_due.push_back(make_result(RES_DATA, 8'h00, 5'd0, 8'h00, 8'h00,
                                                          store[first + i], i == count - 1,
                                                          ERR_BUSY));
                end
            end
            default:
            begin
                if (ph == PH_RCV_ID)
                    id_seen = it.rxb;
                else if ((ph == PH_WAIT_TEMP || ph == PH_WAIT_DATA) && ptr < STORE_BYTES_DEF)
                begin
                    store[ptr]   = it.rxb;
                    written[ptr] = 1'b1;
                    ptr          = ptr + 1'b1;
                end
            end
        endcase
    endfunction

    // host read select that never touches an unwritten store byte
    function automatic logic [1:0] legal_select();
        logic [1:0] pool [$];
        pool.push_back(SEL_NONE);
        if (bytes_written(0, 5))
            pool.push_back(SEL_READINGS);
        if (bytes_written(0, 16))
            pool.push_back(SEL_TABLE_LO);
        if (bytes_written(16, STORE_BYTES_DEF - 16))
            pool.push_back(SEL_TABLE_HI);
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    function automatic sensor_item_t random_item();
        sensor_item_t it;
        it.op    = 2'($urandom);
        it.mbusy = 1'($urandom);
        it.code  = 8'($urandom);
        it.sel   = legal_select();
        it.rxb   = 8'($urandom);
        return it;
    endfunction

    // send one item, with bursts and random gaps on the start side
    task automatic send_item(input sensor_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = steady ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start           <= 1'b1;
        operation       <= it.op;
        master_busy     <= it.mbusy;
        command_code    <= it.code;
        register_select <= it.sel;
        received_byte   <= it.rxb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sequence_step(it);
        items_sent++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] code, input logic [1:0] sel);
        sensor_item_t it;
        it      = random_item();
        it.op   = op;
        it.code = code;
        it.sel  = sel;
        send_item(it);
    endtask

    // wait until no result is due and the job queue has run dry
    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            REG_DEADLINE:   deadline_cfg   = value;
            REG_TEMP_WAIT:  temp_wait_cfg  = value;
            REG_PRESS_WAIT: press_wait_cfg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_WIDTH-1:0] dl, input logic [CFG_WIDTH-1:0] tw,
                              input logic [CFG_WIDTH-1:0] pw);
        drain_block();
        write_reg(REG_DEADLINE, dl);
        write_reg(REG_TEMP_WAIT, tw);
        write_reg(REG_PRESS_WAIT, pw);
    endtask

    // walk the current sequence to idle: id byte, read bytes, ticks, some noise
    task automatic run_sequence(input logic [7:0] code, input logic [7:0] id_value,
                                input int noise_pct, input bit extremes);
        sensor_item_t it;
        phase_t       prior_phase;
        int           bytes_left;
        bit           id_due;
        int           steps;
        bytes_left = 0;
        id_due     = (ph == PH_RCV_ID);
        steps      = 0;
        if (ph == PH_IDLE)
            send_op(OP_COMMAND, code, SEL_NONE);
        while (ph != PH_IDLE && steps < SEQ_STEP_CAP)
        begin
            steps++;
            it = random_item();
            if ($urandom_range(99) < noise_pct)
                ;
            else if (id_due)
            begin
                it.op  = OP_RX_BYTE;
                it.rxb = id_value;
                id_due = 1'b0;
            end
            else if (bytes_left > 0 && (ph == PH_WAIT_TEMP || ph == PH_WAIT_DATA))
            begin
                it.op = OP_RX_BYTE;
                if (extremes)
                    it.rxb = bytes_left[0] ? 8'hff : 8'h00;
                bytes_left--;
            end
            else
            begin
                it.op    = OP_TICK;
                it.mbusy = ($urandom_range(3) == 0);
            end
            prior_phase = ph;
            send_item(it);
            if (ph != prior_phase)
            begin
                case (ph)
                    PH_RCV_ID:    id_due = 1'b1;
                    PH_WAIT_TEMP: bytes_left = 2;
                    PH_WAIT_DATA: bytes_left = (prior_phase == PH_ASK_TABLE) ? LEN_TABLE : 3;
                    default: ;
                endcase
                // short reads now and then
                if (noise_pct > 0 && bytes_left > 0 && $urandom_range(9) == 0)
                    bytes_left = $urandom_range(bytes_left);
            end
        end
    endtask

    // items that idle ignores, and a read with no select
    task automatic test_idle_items();
        sensor_item_t it;
        it       = random_item();
        it.op    = OP_TICK;
        it.mbusy = 1'b1;
        send_item(it);
        it.op  = OP_RX_BYTE;
        it.rxb = 8'hff;
        send_item(it);
        send_op(OP_HOST_READ, 8'h00, SEL_NONE);
    endtask

    // data sequence with zero waits, busy command and busy read on the way
    task automatic test_data_sequence();
        set_config(DEADLINE_RST, 32'd0, 32'd0);
        send_op(OP_COMMAND, 8'hff, SEL_NONE);
        send_op(OP_COMMAND, 8'h00, SEL_NONE);
        send_op(OP_HOST_READ, 8'h00, SEL_TABLE_HI);
        run_sequence(8'hff, DEVICE_ID, 0, 1'b1);
        send_op(OP_HOST_READ, 8'h00, SEL_READINGS);
    endtask

    // id check passes, whole table read back in both halves
    task automatic test_calibration();
        run_sequence(CMD_CALIBRATE, DEVICE_ID, 0, 1'b1);
        send_op(OP_HOST_READ, 8'h00, SEL_TABLE_LO);
        send_op(OP_HOST_READ, 8'h00, SEL_TABLE_HI);
    endtask

    task automatic test_bad_id();
        run_sequence(CMD_CALIBRATE, 8'haa, 0, 1'b0);
    endtask

    // smallest nonzero deadline aborts the data sequence
    task automatic test_deadline();
        set_config(32'd1, 32'd0, 32'd0);
        run_sequence(8'h00, DEVICE_ID, 0, 1'b0);
    endtask

    // random sequences and noise under several register settings
    task automatic test_random();
        int goal;
        for (int k = 0; k < 5; k++)
        begin
            case (k)
                0: set_config(DEADLINE_RST, TEMP_WAIT_RST, PRESS_WAIT_RST);
                1: set_config(32'hffff_ffff, $urandom_range(0, 6), $urandom_range(0, 6));
                2: set_config($urandom_range(8, 40), 32'hffff_ffff, 32'd0);
                3: set_config(32'd30, 32'd2, 32'hffff_ffff);
                default: set_config($urandom_range(5, 200), $urandom_range(0, 20),
                                    $urandom_range(0, 20));
            endcase
            steady = (k == 1);
            goal = items_sent + 5;
            while (items_sent < goal)
            begin
                if ($urandom_range(99) < 20)
                    send_item(random_item());
                else
                    run_sequence(($urandom_range(9) < 4) ? CMD_CALIBRATE : 8'($urandom),
                                 ($urandom_range(9) < 8) ? DEVICE_ID : 8'($urandom),
                                 8, 1'b0);
            end
        end
        steady = 1'b0;
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // compare each result with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual kind %0h", $time,
                         result_kind);
                mismatches++;
            end
            else
            begin
                checked = results_due.pop_front();
                check_field("result_kind", 8'(checked.kind), 8'(result_kind));
                check_field("bus_address", checked.bus_address, bus_address);
                check_field("transfer_length", 8'(checked.transfer_length),
                            8'(transfer_length));
                check_field("send_first", checked.send_first, send_first);
                check_field("send_second", checked.send_second, send_second);
                check_field("read_data", checked.read_data, read_data);
                check_field("last_of_run", 8'(checked.last_of_run), 8'(last_of_run));
                check_field("error_code", 8'(checked.error_code), 8'(error_code));
            end
        end
    end

    // watchdog on cycles with no item, result or register write
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t watchdog: no activity for %0d cycles", $time, quiet);
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        operation       = OP_TICK;
        master_busy     = 1'b0;
        command_code    = 8'h00;
        register_select = SEL_NONE;
        received_byte   = 8'h00;
        cfg_valid       = 1'b0;
        cfg_index       = REG_DEADLINE;
        cfg_data        = '0;
        ph              = PH_IDLE;
        elapsed         = '0;
        ptr             = 5'd0;
        id_seen         = 8'h00;
        deadline_cfg    = DEADLINE_RST;
        temp_wait_cfg   = TEMP_WAIT_RST;
        press_wait_cfg  = PRESS_WAIT_RST;
        mismatches      = 0;
        items_sent      = 0;
        burst_left      = 0;
        steady          = 1'b0;
        quiet           = 0;
        for (int i = 0; i < STORE_BYTES_DEF; i++)
        begin
            store[i]   = 8'h00;
            written[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_items();
        test_data_sequence();
        test_calibration();
        test_bad_id();
        test_deadline();
        test_random();

        drain_block();
        repeat (16) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $display("%0t results never seen: expected 0 left, actual %0d", $time,
                     results_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
